### sv/srrps_pkg.sv
// ----------------------------------------------------------------------------
// srrps_pkg
// Shared types and protocol constants for the sticky round-robin packet
// steering unit.
// ----------------------------------------------------------------------------
package srrps_pkg;

   // frame length thresholds in bytes
   localparam logic [15:0] MIN_ETH_LEN   = 16'd14;
   localparam logic [15:0] MIN_IP_LEN    = 16'd34;
   localparam logic [15:0] MIN_L4_LEN    = 16'd42;

   // header codes
   localparam logic [15:0] ETYPE_ARP     = 16'h0806;
   localparam logic [7:0]  PROTO_ICMP    = 8'd1;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [7:0]  PROTO_ESP     = 8'd50;
   localparam logic [7:0]  ICMP_ECHO_REQ = 8'd8;
   localparam logic [15:0] ISAKMP_PORT   = 16'd500;
   localparam logic [7:0]  ARP_PORT      = 8'd1;

   // endpoint count after reset
   localparam logic [7:0]  EP_COUNT_RST  = 8'd2;

   // how a frame is handled
   typedef enum logic [1:0] {
      CLS_DROP  = 2'd0,
      CLS_ARP   = 2'd1,
      CLS_LEARN = 2'd2,
      CLS_ESP   = 2'd3
   } class_type;

   // one stored table entry
   typedef struct packed {
      logic [31:0] src_ip;
      logic [7:0]  port;
   } entry_type;

   // one result beat
   typedef struct packed {
      logic       verdict;
      logic [7:0] egress_port;
      logic       learned;
      logic       table_full;
   } result_type;

   localparam result_type RESULT_DROP = '{verdict: 1'b0, egress_port: 8'd0,
                                          learned: 1'b0, table_full: 1'b0};

endpackage

### sv/srrps_classify.sv
// ----------------------------------------------------------------------------
// srrps_classify
// Decodes the header summary of a frame into its handling class.
// ----------------------------------------------------------------------------
module srrps_classify (
   input  logic [15:0]          frame_length,
   input  logic [15:0]          ethertype,
   input  logic [7:0]           ip_protocol,
   input  logic [7:0]           icmp_type,
   input  logic [15:0]          udp_dest_port,
   output srrps_pkg::class_type frame_class
);
   import srrps_pkg::*;

   logic len_ip_ok;
   logic len_l4_ok;

   assign len_ip_ok = (frame_length >= MIN_ETH_LEN) && (frame_length >= MIN_IP_LEN);
   assign len_l4_ok = (frame_length >= MIN_L4_LEN);

   // short frames drop first, then arp, then per protocol
   always_comb begin
      frame_class = CLS_DROP;
      if (!len_ip_ok) begin
         frame_class = CLS_DROP;
      end else if (ethertype == ETYPE_ARP) begin
         frame_class = CLS_ARP;
      end else if (ip_protocol == PROTO_ICMP) begin
         if (len_l4_ok && icmp_type == ICMP_ECHO_REQ) frame_class = CLS_LEARN;
      end else if (ip_protocol == PROTO_ESP) begin
         if (len_l4_ok) frame_class = CLS_ESP;
      end else if (ip_protocol == PROTO_UDP && udp_dest_port == ISAKMP_PORT &&
                   len_l4_ok) begin
         frame_class = CLS_LEARN;
      end
   end

endmodule

### sv/srrps_table.sv
// ----------------------------------------------------------------------------
// srrps_table
// Source address table: one synchronous memory of address and port pairs,
// one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srrps_table #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_idx,
   input  srrps_pkg::entry_type wr_data,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_idx,
   output srrps_pkg::entry_type rd_data
);
   import srrps_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_idx] <= wr_data;
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem_ff[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/sticky_round_robin_packet_steering_unit.sv
// ----------------------------------------------------------------------------
// sticky_round_robin_packet_steering_unit
// Steers frames by source address with a learned table and a round robin
// over the configured tunnel endpoints.
// ----------------------------------------------------------------------------
// One frame is handled at a time. Dropped and ARP frames skip the scan and
// go from accept to the result register. ICMP echo, UDP port 500 and ESP
// frames scan the learned entries in fill order through the single memory
// read port, one entry per cycle, until a hit or the end of the filled
// entries. A new frame is accepted while a finished result still waits on
// the rsp side. The table starts empty after reset with no clearing pass;
// entries are kept in fill order and are never freed. endpoint_count may
// be written at any time the unit is idle.
// ----------------------------------------------------------------------------
module sticky_round_robin_packet_steering_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_endpoint_count,
   // frame headers
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_frame_length,
   input  logic [15:0] req_ethertype,
   input  logic [7:0]  req_ip_protocol,
   input  logic [7:0]  req_icmp_type,
   input  logic [15:0] req_udp_dest_port,
   input  logic [31:0] req_src_ip,
   // verdicts
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_verdict,
   output logic [7:0]  rsp_egress_port,
   output logic        rsp_learned,
   output logic        rsp_table_full
);
   import srrps_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [7:0]       ep_count_ff, ep_count_in;
   logic [8:0]       rr_ff, rr_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic [31:0]      key_ff, key_in;
   class_type        cls_ff, cls_in;
   result_type       res_ff, res_in;
   result_type       rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   class_type        req_class;
   logic             tbl_wr_en;
   logic             tbl_rd_en;
   entry_type        tbl_wr_data;
   entry_type        tbl_rd_data;
   logic [8:0]       rr_step;
   logic [8:0]       rr_next;

   srrps_classify u_classify (
      .frame_length  (req_frame_length),
      .ethertype     (req_ethertype),
      .ip_protocol   (req_ip_protocol),
      .icmp_type     (req_icmp_type),
      .udp_dest_port (req_udp_dest_port),
      .frame_class   (req_class)
   );

   srrps_table #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_idx  (used_ff[IDX_W-1:0]),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_idx  (issue_ff[IDX_W-1:0]),
      .rd_data (tbl_rd_data)
   );

   // round robin advance over 1..endpoint_count
   assign rr_step = rr_ff + 9'd1;
   assign rr_next = (rr_step > {1'b0, ep_count_ff}) ? 9'd1 : rr_step;

   assign tbl_wr_data = '{src_ip: key_ff, port: rr_next[7:0]};

   // control: accept, scan (learn and ESP classes only), then hand the result
   // to the output register; a learn write lands before the next frame can start its scan
   always_comb begin
      state_in     = state_ff;
      ep_count_in  = ep_count_ff;
      rr_in        = rr_ff;
      used_in      = used_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      key_in       = key_ff;
      cls_in       = cls_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      tbl_wr_en    = 1'b0;
      tbl_rd_en    = 1'b0;

      if (csr_valid) ep_count_in = csr_endpoint_count;
      if (rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = req_src_ip;
               cls_in   = req_class;
               issue_in = '0;
               pend_in  = 1'b0;
               case (req_class)
                  CLS_DROP: begin
                     res_in   = RESULT_DROP;
                     state_in = S_DONE;
                  end
                  CLS_ARP: begin
                     res_in   = '{verdict: 1'b1, egress_port: ARP_PORT,
                                  learned: 1'b0, table_full: 1'b0};
                     state_in = S_DONE;
                  end
                  default: state_in = S_SCAN;
               endcase
            end
         end
         S_SCAN: begin
            if (pend_ff && tbl_rd_data.src_ip == key_ff) begin
               // hit
               res_in   = '{verdict: 1'b1, egress_port: tbl_rd_data.port,
                            learned: 1'b0, table_full: 1'b0};
               state_in = S_DONE;
            end else if (!pend_ff && issue_ff == used_ff) begin
               // miss
               state_in = S_DONE;
               if (cls_ff == CLS_ESP) begin
                  res_in = RESULT_DROP;
               end else begin
                  rr_in = rr_next;
                  if (used_ff < DEPTH_CNT) begin
                     tbl_wr_en = 1'b1;
                     used_in   = used_ff + CNT_W'(1);
                     res_in    = '{verdict: 1'b1, egress_port: rr_next[7:0],
                                   learned: 1'b1, table_full: 1'b0};
                  end else begin
                     res_in    = '{verdict: 1'b1, egress_port: rr_next[7:0],
                                   learned: 1'b0, table_full: 1'b1};
                  end
               end
            end else if (issue_ff < used_ff) begin
               tbl_rd_en = 1'b1;
               issue_in  = issue_ff + CNT_W'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in   = 1'b0;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ep_count_ff  <= EP_COUNT_RST;
         rr_ff        <= '0;
         used_ff      <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ep_count_ff  <= ep_count_in;
         rr_ff        <= rr_in;
         used_ff      <= used_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      cls_ff <= cls_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign csr_ready       = 1'b1;
   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_ff.verdict;
   assign rsp_egress_port = rsp_ff.egress_port;
   assign rsp_learned     = rsp_ff.learned;
   assign rsp_table_full  = rsp_ff.table_full;

   // fill count never passes the table size
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= DEPTH_CNT)
      else $error("table fill count beyond depth");

   // scan never reads past the filled entries
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      tbl_rd_en |-> issue_ff < used_ff)
      else $error("scan read beyond filled entries");

   // a learn grows the fill count by exactly one
   a_learn_fill: assert property (@(posedge clock) disable iff (reset)
      tbl_wr_en |=> used_ff == $past(used_ff) + CNT_W'(1))
      else $error("learn did not advance fill count");

   // learned and full are exclusive and imply a redirect to a nonzero port
   a_learn_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.learned || rsp_ff.table_full) |->
         rsp_ff.verdict && !(rsp_ff.learned && rsp_ff.table_full) &&
         rsp_ff.egress_port != 8'd0)
      else $error("inconsistent learn result");

endmodule
